### hdl/mss_pkg.sv
package mss_pkg;

    // fixed field widths
    localparam int DUTY_W     = 9;
    localparam int DVAL_W     = 10;
    localparam int NOW_W      = 32;
    localparam int CFG_W      = 24;
    localparam int ACT_W      = 2;
    localparam int PHASE_W    = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 16;

    localparam int TIME_BITS_DEF = 24;

    // compare value that means the motor is stopped
    localparam logic [DUTY_W-1:0] STOP_DUTY = 9'd500;

    typedef enum logic [ACT_W-1:0] {
        ACT_TICK  = 2'd0,
        ACT_START = 2'd1,
        ACT_STOP  = 2'd2,
        ACT_DUTY  = 2'd3
    } t_action;

    typedef enum logic [PHASE_W-1:0] {
        PH_IDLE = 2'd0,
        PH_WAIT = 2'd1,
        PH_RUN  = 2'd2,
        PH_STOP = 2'd3
    } t_phase;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WAIT   = 2'd0,
        CFG_RUN    = 2'd1,
        CFG_RAMP   = 2'd2,
        CFG_TARGET = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic load;
        logic div_start;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic need_div;
        logic div_done;
    } t_sts;

endpackage

### hdl/mss_div.sv
module mss_div #(
    parameter int TIME_BITS = mss_pkg::TIME_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_start,
    input  logic [mss_pkg::DUTY_W+TIME_BITS-1:0]  i_dividend,
    input  logic [TIME_BITS-1:0]                  i_divisor,
    output logic                                  o_done,
    output logic [mss_pkg::DUTY_W-1:0]            o_quot
);

    localparam int QW    = mss_pkg::DUTY_W;
    localparam int DIV_W = QW + TIME_BITS;
    localparam int CNT_W = $clog2(QW);

    logic                 r_busy;
    logic                 r_done;
    logic [CNT_W-1:0]     r_cnt;
    logic [TIME_BITS-1:0] r_rem;
    logic [TIME_BITS-1:0] r_dvs;
    logic [QW-1:0]        r_quot;

    logic [TIME_BITS:0]   trial;
    logic [TIME_BITS:0]   diff;
    logic                 ge;
    logic [TIME_BITS-1:0] n_rem;

    // quotient is known to fit in QW bits, so the upper dividend part starts below the divisor
    always_comb begin
        trial = {r_rem, r_quot[QW-1]};
        ge    = trial >= {1'b0, r_dvs};
        diff  = trial - {1'b0, r_dvs};
        n_rem = ge ? diff[TIME_BITS-1:0] : trial[TIME_BITS-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + CNT_W'(1);
            if (r_cnt == CNT_W'(QW - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= i_dividend[DIV_W-1:QW];
            r_quot <= i_dividend[QW-1:0];
            r_dvs  <= i_divisor;
        end else if (r_busy) begin
            r_rem  <= n_rem;
            r_quot <= {r_quot[QW-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

### hdl/mss_dp.sv
module mss_dp #(
    parameter int TIME_BITS = mss_pkg::TIME_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [mss_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [mss_pkg::CFG_W-1:0]         i_cfg_data,
    input  logic [mss_pkg::ACT_W-1:0]         i_action,
    input  logic [mss_pkg::NOW_W-1:0]         i_now_ms,
    input  logic [mss_pkg::DVAL_W-1:0]        i_duty_value,
    input  mss_pkg::t_cmd                     i_cmd,
    output mss_pkg::t_sts                     o_sts,
    output logic [mss_pkg::OUT_DATA_W-1:0]    o_result
);

    localparam int DW    = mss_pkg::DUTY_W;
    localparam int TW    = mss_pkg::NOW_W;
    localparam int DIV_W = DW + TIME_BITS;

    // configuration registers
    logic [mss_pkg::CFG_W-1:0] r_cfg_wait;
    logic [mss_pkg::CFG_W-1:0] r_cfg_run;
    logic [mss_pkg::CFG_W-1:0] r_cfg_ramp;
    logic [DW-1:0]             r_cfg_target;

    // item being worked on
    mss_pkg::t_action          r_action;
    logic [TW-1:0]             r_now;
    logic [TW-1:0]             r_elapsed;
    logic [mss_pkg::DVAL_W-1:0] r_dval;

    // sequencer state
    mss_pkg::t_phase           r_phase;
    logic [TW-1:0]             r_pst;
    logic [DW-1:0]             r_duty;
    logic                      r_ramp_on;
    logic                      r_start_pend;
    logic                      r_work;
    logic [TIME_BITS-1:0]      r_snap_wait;
    logic [TIME_BITS-1:0]      r_snap_run;
    logic [TIME_BITS-1:0]      r_snap_ramp;
    logic [DW-1:0]             r_snap_target;
    logic [mss_pkg::OUT_DATA_W-1:0] r_result;

    mss_pkg::t_phase           n_phase;
    logic [TW-1:0]             n_pst;
    logic [DW-1:0]             n_duty;
    logic                      n_ramp_on;
    logic                      n_start_pend;
    logic                      n_work;
    logic [TIME_BITS-1:0]      n_snap_wait;
    logic [TIME_BITS-1:0]      n_snap_run;
    logic [TIME_BITS-1:0]      n_snap_ramp;
    logic [DW-1:0]             n_snap_target;
    logic                      n_written;
    logic                      n_finished;
    logic                      n_rejected;

    logic [DW-1:0]             target_clamp;
    logic [DW-1:0]             span;
    logic                      ramp_end;
    logic                      ramp_end0;
    logic                      need_div;
    logic [DIV_W-1:0]          dividend;
    logic                      div_done;
    logic [DW-1:0]             quot;
    logic [TW-1:0]             cfg_wait_x;
    logic [TW-1:0]             cfg_run_x;
    logic [TW-1:0]             cfg_ramp_x;

    mss_div #(
        .TIME_BITS (TIME_BITS)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (dividend),
        .i_divisor  (r_snap_ramp),
        .o_done     (div_done),
        .o_quot     (quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_wait   <= '0;
            r_cfg_run    <= '0;
            r_cfg_ramp   <= '0;
            r_cfg_target <= mss_pkg::STOP_DUTY;
        end else if (i_cfg_we) begin
            unique case (mss_pkg::t_cfg_idx'(i_cfg_index))
                mss_pkg::CFG_WAIT:   r_cfg_wait   <= i_cfg_data;
                mss_pkg::CFG_RUN:    r_cfg_run    <= i_cfg_data;
                mss_pkg::CFG_RAMP:   r_cfg_ramp   <= i_cfg_data;
                mss_pkg::CFG_TARGET: r_cfg_target <= i_cfg_data[DW-1:0];
            endcase
        end
    end

    // elapsed time is taken against the phase start as the item comes in
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_action  <= mss_pkg::t_action'(i_action);
            r_now     <= i_now_ms;
            r_dval    <= i_duty_value;
            r_elapsed <= i_now_ms - r_pst;
        end
    end

    always_comb begin
        target_clamp = (r_snap_target > mss_pkg::STOP_DUTY) ? mss_pkg::STOP_DUTY
                                                            : r_snap_target;
        span      = mss_pkg::STOP_DUTY - r_snap_target;
        ramp_end0 = (r_snap_ramp == '0) || (r_snap_target >= mss_pkg::STOP_DUTY);
        ramp_end  = ramp_end0 || (r_elapsed >= TW'(r_snap_ramp));
        need_div  = (r_action == mss_pkg::ACT_TICK) && (r_phase == mss_pkg::PH_RUN)
                    && r_ramp_on && !ramp_end;
        // elapsed is below the ramp length here, so its low bits carry it all
        dividend  = DIV_W'(span) * DIV_W'(r_elapsed[TIME_BITS-1:0]);
        cfg_wait_x = TW'(r_cfg_wait);
        cfg_run_x  = TW'(r_cfg_run);
        cfg_ramp_x = TW'(r_cfg_ramp);
    end

    always_comb begin
        n_phase       = r_phase;
        n_pst         = r_pst;
        n_duty        = r_duty;
        n_ramp_on     = r_ramp_on;
        n_start_pend  = r_start_pend;
        n_work        = r_work;
        n_snap_wait   = r_snap_wait;
        n_snap_run    = r_snap_run;
        n_snap_ramp   = r_snap_ramp;
        n_snap_target = r_snap_target;
        n_written     = 1'b0;
        n_finished    = 1'b0;
        n_rejected    = 1'b0;

        unique case (r_action)
            mss_pkg::ACT_START: begin
                n_start_pend = 1'b1;
            end
            mss_pkg::ACT_STOP: begin
                if (n_duty != mss_pkg::STOP_DUTY) begin
                    n_duty    = mss_pkg::STOP_DUTY;
                    n_written = 1'b1;
                end
                n_ramp_on    = 1'b0;
                n_work       = 1'b0;
                n_start_pend = 1'b0;
                n_phase      = mss_pkg::PH_IDLE;
            end
            mss_pkg::ACT_DUTY: begin
                if (r_dval > mss_pkg::DVAL_W'(mss_pkg::STOP_DUTY)) begin
                    n_rejected = 1'b1;
                end else if (n_duty != r_dval[DW-1:0]) begin
                    n_duty    = r_dval[DW-1:0];
                    n_written = 1'b1;
                end
            end
            mss_pkg::ACT_TICK: begin
                unique case (r_phase)
                    mss_pkg::PH_IDLE: begin
                        if (r_start_pend) begin
                            n_start_pend  = 1'b0;
                            n_snap_wait   = cfg_wait_x[TIME_BITS-1:0];
                            n_snap_run    = cfg_run_x[TIME_BITS-1:0];
                            n_snap_ramp   = cfg_ramp_x[TIME_BITS-1:0];
                            n_snap_target = r_cfg_target;
                            n_pst         = r_now;
                            n_phase       = mss_pkg::PH_WAIT;
                        end
                    end
                    mss_pkg::PH_WAIT: begin
                        if (r_elapsed >= TW'(r_snap_wait)) begin
                            if (n_duty != mss_pkg::STOP_DUTY) begin
                                n_duty    = mss_pkg::STOP_DUTY;
                                n_written = 1'b1;
                            end
                            // first ramp point sits at zero elapsed time
                            if (ramp_end0) begin
                                if (n_duty != target_clamp) begin
                                    n_duty    = target_clamp;
                                    n_written = 1'b1;
                                end
                                n_ramp_on = 1'b0;
                            end else begin
                                n_ramp_on = 1'b1;
                            end
                            n_work  = 1'b1;
                            n_pst   = r_now;
                            n_phase = mss_pkg::PH_RUN;
                        end
                    end
                    mss_pkg::PH_RUN: begin
                        if (r_ramp_on) begin
                            if (ramp_end) begin
                                if (n_duty != target_clamp) begin
                                    n_duty    = target_clamp;
                                    n_written = 1'b1;
                                end
                                n_ramp_on = 1'b0;
                            end else if (n_duty != (mss_pkg::STOP_DUTY - quot)) begin
                                n_duty    = mss_pkg::STOP_DUTY - quot;
                                n_written = 1'b1;
                            end
                        end
                        if (r_elapsed >= TW'(r_snap_run)) begin
                            n_phase = mss_pkg::PH_STOP;
                        end
                    end
                    mss_pkg::PH_STOP: begin
                        if (n_duty != mss_pkg::STOP_DUTY) begin
                            n_duty    = mss_pkg::STOP_DUTY;
                            n_written = 1'b1;
                        end
                        n_ramp_on    = 1'b0;
                        n_work       = 1'b0;
                        n_start_pend = 1'b0;
                        n_phase      = mss_pkg::PH_IDLE;
                        n_finished   = 1'b1;
                    end
                endcase
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= mss_pkg::PH_IDLE;
            r_pst         <= '0;
            r_duty        <= mss_pkg::STOP_DUTY;
            r_ramp_on     <= 1'b0;
            r_start_pend  <= 1'b0;
            r_work        <= 1'b0;
            r_snap_wait   <= '0;
            r_snap_run    <= '0;
            r_snap_ramp   <= '0;
            r_snap_target <= mss_pkg::STOP_DUTY;
        end else if (i_cmd.commit) begin
            r_phase       <= n_phase;
            r_pst         <= n_pst;
            r_duty        <= n_duty;
            r_ramp_on     <= n_ramp_on;
            r_start_pend  <= n_start_pend;
            r_work        <= n_work;
            r_snap_wait   <= n_snap_wait;
            r_snap_run    <= n_snap_run;
            r_snap_ramp   <= n_snap_ramp;
            r_snap_target <= n_snap_target;
        end
    end

    // result word, lowest bits first: duty, written, running, phase, finished, status
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_result <= {1'b0, n_rejected, n_finished, n_phase, n_work, n_written, n_duty};
        end
    end

    assign o_sts.need_div = need_div;
    assign o_sts.div_done = div_done;
    assign o_result       = r_result;

endmodule

### hdl/mss_ctrl.sv
module mss_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_out_ready,
    input  mss_pkg::t_sts i_sts,
    output logic          o_in_ready,
    output logic          o_out_valid,
    output mss_pkg::t_cmd o_cmd
);

    typedef enum logic [1:0] {
        ST_READY,
        ST_EVAL,
        ST_DIV,
        ST_OUT
    } t_state;

    t_state r_state;
    logic   r_in_ready;
    logic   r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_READY;
            r_in_ready  <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                ST_READY: begin
                    if (i_in_valid) begin
                        r_state    <= ST_EVAL;
                        r_in_ready <= 1'b0;
                    end
                end
                ST_EVAL: begin
                    if (i_sts.need_div) begin
                        r_state <= ST_DIV;
                    end else begin
                        r_state     <= ST_OUT;
                        r_out_valid <= 1'b1;
                    end
                end
                ST_DIV: begin
                    if (i_sts.div_done) begin
                        r_state     <= ST_OUT;
                        r_out_valid <= 1'b1;
                    end
                end
                ST_OUT: begin
                    if (i_out_ready) begin
                        r_state     <= ST_READY;
                        r_out_valid <= 1'b0;
                        r_in_ready  <= 1'b1;
                    end
                end
            endcase
        end
    end

    always_comb begin
        o_cmd.load      = (r_state == ST_READY) && i_in_valid;
        o_cmd.div_start = (r_state == ST_EVAL) && i_sts.need_div;
        o_cmd.commit    = ((r_state == ST_EVAL) && !i_sts.need_div)
                          || ((r_state == ST_DIV) && i_sts.div_done);
    end

    assign o_in_ready  = r_in_ready;
    assign o_out_valid = r_out_valid;

endmodule

### hdl/motor_soft_start_sequencer.sv
// channel   dir  handshake                        payload
// s_axis    in   s_axis_tvalid / s_axis_tready    tdata: now_ms, duty_value; tuser: action
// m_axis    out  m_axis_tvalid / m_axis_tready    tdata: duty_cmp .. status
// cfg       in   i_cfg_valid / o_cfg_ready        i_cfg_index, i_cfg_data
//
// one item at a time: the result is registered after the item is evaluated, and after the divider
// when a ramp point is computed (one quotient bit per cycle of the restoring divider, 9 bits)
// the next item can be taken in the cycle after the result transfer
// synchronous active-low reset; stop duty applied, phase idle
// a stalled result holds its data and keeps s_axis_tready low
module motor_soft_start_sequencer #(
    parameter int TIME_BITS = mss_pkg::TIME_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // [31:0] now_ms, [41:32] duty_value, [47:42] zero
    input  logic [mss_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // [1:0] action
    input  logic [mss_pkg::ACT_W-1:0]         s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [8:0] duty_cmp, [9] duty_written, [10] running, [12:11] phase,
    // [13] cycle_finished, [14] status, [15] zero
    output logic [mss_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [mss_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [mss_pkg::CFG_W-1:0]         i_cfg_data
);

    mss_pkg::t_cmd cmd;
    mss_pkg::t_sts sts;

    assign o_cfg_ready = 1'b1;

    mss_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_sts       (sts),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_cmd       (cmd)
    );

    mss_dp #(
        .TIME_BITS (TIME_BITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_valid),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_action     (s_axis_tuser),
        .i_now_ms     (s_axis_tdata[mss_pkg::NOW_W-1:0]),
        .i_duty_value (s_axis_tdata[mss_pkg::NOW_W+mss_pkg::DVAL_W-1:mss_pkg::NOW_W]),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .o_result     (m_axis_tdata)
    );

endmodule

### hdl/mss_chk.sv
module mss_chk (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tready,
    input  logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    input  logic [mss_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);

    logic [1:0] out_phase;
    logic       out_running;
    logic       out_written;
    logic       out_finished;
    logic       out_status;

    assign out_written  = m_axis_tdata[9];
    assign out_running  = m_axis_tdata[10];
    assign out_phase    = m_axis_tdata[12:11];
    assign out_finished = m_axis_tdata[13];
    assign out_status   = m_axis_tdata[14];

    // no new item while a result is still pending
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input taken while result pending");

    a_finish_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && out_finished) |->
            (out_phase == mss_pkg::PH_IDLE && !out_running))
        else $error("finished cycle not back in idle");

    a_reject_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && out_status) |-> !out_written)
        else $error("rejected duty still written");

    a_running_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |->
            (out_running == (out_phase == mss_pkg::PH_RUN || out_phase == mss_pkg::PH_STOP)))
        else $error("work flag disagrees with phase");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled result changed");

endmodule

bind motor_soft_start_sequencer mss_chk u_mss_chk (.*);

### verif/motor_soft_start_sequencer_tb.sv
module motor_soft_start_sequencer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RUN_LIMIT = 1000000;
    localparam int SETTLE_CYCLES = 16;

    typedef struct {
        mss_pkg::t_action           act;
        logic [mss_pkg::NOW_W-1:0]  now;
        logic [mss_pkg::DVAL_W-1:0] dval;
    } t_motor_cmd;

    // same layout as m_axis_tdata[14:0]
    typedef struct packed {
        logic                       status;
        logic                       finished;
        mss_pkg::t_phase            phase;
        logic                       running;
        logic                       written;
        logic [mss_pkg::DUTY_W-1:0] duty;
    } t_motor_report;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           s_axis_tvalid = 1'b0;
    logic                           s_axis_tready;
    logic [mss_pkg::IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic [mss_pkg::ACT_W-1:0]      s_axis_tuser = '0;
    logic                           m_axis_tvalid;
    logic                           m_axis_tready = 1'b0;
    logic [mss_pkg::OUT_DATA_W-1:0] m_axis_tdata;
    logic                           i_cfg_valid = 1'b0;
    logic                           o_cfg_ready;
    logic [mss_pkg::CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [mss_pkg::CFG_W-1:0]      i_cfg_data = '0;

    t_motor_cmd    cmd_queue[$];
    t_motor_report report_queue[$];

    int send_idle_pct = 0;
    int stall_pct = 0;
    int mismatch_count = 0;
    int cycle_count = 0;

    // register copies as written over the config channel
    logic [mss_pkg::CFG_W-1:0]  cfg_wait_ms, cfg_run_ms, cfg_ramp_ms;
    logic [mss_pkg::DUTY_W-1:0] cfg_target;

    // sequencer state as predicted
    mss_pkg::t_phase            seq_phase;
    logic [mss_pkg::NOW_W-1:0]  seq_t0;
    logic [mss_pkg::DUTY_W-1:0] duty_cur;
    logic                       ramp_on, start_held, drive_on, duty_changed;
    logic [mss_pkg::CFG_W-1:0]  lat_wait, lat_run, lat_ramp;
    logic [mss_pkg::DUTY_W-1:0] lat_target;

    motor_soft_start_sequencer uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    function automatic void set_duty(input logic [31:0] d);
        if (d > 32'(mss_pkg::STOP_DUTY)) d = 32'(mss_pkg::STOP_DUTY);
        if (duty_cur != d[mss_pkg::DUTY_W-1:0]) begin
            duty_cur = d[mss_pkg::DUTY_W-1:0];
            duty_changed = 1'b1;
        end
    endfunction

    function automatic void ramp_update(input logic [mss_pkg::NOW_W-1:0] now);
        logic [mss_pkg::NOW_W-1:0] elapsed;
        logic [63:0]               drop;
        if (ramp_on) begin
            elapsed = now - seq_t0;
            if (lat_ramp == '0 || elapsed >= 32'(lat_ramp) ||
                lat_target >= mss_pkg::STOP_DUTY) begin
                set_duty(32'(lat_target));
                ramp_on = 1'b0;
            end else begin
                drop = (64'(mss_pkg::STOP_DUTY) - 64'(lat_target)) * 64'(elapsed)
                       / 64'(lat_ramp);
                set_duty(32'(mss_pkg::STOP_DUTY) - drop[31:0]);
            end
        end
    endfunction

    function automatic void stop_motor();
        set_duty(32'(mss_pkg::STOP_DUTY));
        ramp_on = 1'b0;
        drive_on = 1'b0;
        start_held = 1'b0;
        seq_phase = mss_pkg::PH_IDLE;
    endfunction

    function automatic t_motor_report advance_sequencer(input t_motor_cmd c);
        t_motor_report r;
        logic fin, rej;
        fin = 1'b0;
        rej = 1'b0;
        duty_changed = 1'b0;
        case (c.act)
            mss_pkg::ACT_START: start_held = 1'b1;
            mss_pkg::ACT_STOP: stop_motor();
            mss_pkg::ACT_DUTY: begin
                if (c.dval > 10'(mss_pkg::STOP_DUTY)) rej = 1'b1;
                else set_duty(32'(c.dval));
            end
            default: begin
                case (seq_phase)
                    mss_pkg::PH_IDLE: begin
                        if (start_held) begin
                            start_held = 1'b0;
                            lat_wait = cfg_wait_ms;
                            lat_run = cfg_run_ms;
                            lat_ramp = cfg_ramp_ms;
                            lat_target = cfg_target;
                            seq_t0 = c.now;
                            seq_phase = mss_pkg::PH_WAIT;
                        end
                    end
                    mss_pkg::PH_WAIT: begin
                        if (c.now - seq_t0 >= 32'(lat_wait)) begin
                            set_duty(32'(mss_pkg::STOP_DUTY));
                            ramp_on = 1'b1;
                            drive_on = 1'b1;
                            seq_t0 = c.now;
                            seq_phase = mss_pkg::PH_RUN;
                            ramp_update(c.now);
                        end
                    end
                    mss_pkg::PH_RUN: begin
                        ramp_update(c.now);
                        if (c.now - seq_t0 >= 32'(lat_run)) seq_phase = mss_pkg::PH_STOP;
                    end
                    default: begin
                        stop_motor();
                        fin = 1'b1;
                    end
                endcase
            end
        endcase
        r.duty = duty_cur;
        r.written = duty_changed;
        r.running = drive_on;
        r.phase = seq_phase;
        r.finished = fin;
        r.status = rej;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        $display("%0t ns: %s got %0d want %0d", $time, what, got, want);
        mismatch_count++;
    endtask

    task automatic compare_field(input string what, input int unsigned got,
                                 input int unsigned want);
        if (got != want) report_mismatch(what, got, want);
    endtask

    // driver: one item per transfer, random gaps between items
    always @(posedge i_clk) begin : drive_items
        t_motor_cmd c;
        logic fire;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            fire = s_axis_tvalid && s_axis_tready;
            if (fire) begin
                c.act = mss_pkg::t_action'(s_axis_tuser);
                c.now = s_axis_tdata[31:0];
                c.dval = s_axis_tdata[41:32];
                report_queue.push_back(advance_sequencer(c));
            end
            if (!s_axis_tvalid || fire) begin
                if (cmd_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    c = cmd_queue.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= {6'd0, c.dval, c.now};
                    s_axis_tuser <= c.act;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor and receiver stalls
    always @(posedge i_clk) begin : check_reports
        t_motor_report got, want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = t_motor_report'(m_axis_tdata[14:0]);
                if (report_queue.size() == 0) begin
                    report_mismatch("result with none outstanding, duty", 32'(got.duty),
                                    32'd0);
                end else begin
                    want = report_queue.pop_front();
                    compare_field("duty_cmp", 32'(got.duty), 32'(want.duty));
                    compare_field("duty_written", 32'(got.written), 32'(want.written));
                    compare_field("running", 32'(got.running), 32'(want.running));
                    compare_field("phase", 32'(got.phase), 32'(want.phase));
                    compare_field("cycle_finished", 32'(got.finished), 32'(want.finished));
                    compare_field("status", 32'(got.status), 32'(want.status));
                end
            end
            m_axis_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == RUN_LIMIT) begin
            $display("motor_soft_start_sequencer: mismatch");
            $finish;
        end
    end

    function automatic void queue_cmd(input mss_pkg::t_action a,
                                      input logic [mss_pkg::NOW_W-1:0] now,
                                      input logic [mss_pkg::DVAL_W-1:0] dval);
        t_motor_cmd c;
        c.act = a;
        c.now = now;
        c.dval = dval;
        cmd_queue.push_back(c);
    endfunction

    function automatic void queue_noise();
        mss_pkg::t_action a;
        logic [mss_pkg::DVAL_W-1:0] d;
        a = mss_pkg::t_action'($urandom_range(3));
        d = $urandom_range(1) ? mss_pkg::DVAL_W'($urandom_range(500))
                              : mss_pkg::DVAL_W'($urandom_range(1023));
        queue_cmd(a, $urandom(), d);
    endfunction

    // mostly complete start/wait/run/stop sequences, some stray items
    function automatic void queue_random(input int n);
        int unsigned span, t;
        int left, k;
        left = n;
        while (left > 0) begin
            if ($urandom_range(99) < 80) begin
                span = int'(cfg_wait_ms) + int'(cfg_run_ms) + 1;
                t = $urandom();
                queue_cmd(mss_pkg::ACT_START, $urandom(),
                          mss_pkg::DVAL_W'($urandom_range(1023)));
                queue_cmd(mss_pkg::ACT_TICK, t, mss_pkg::DVAL_W'($urandom_range(1023)));
                k = $urandom_range(20, 6);
                left -= k + 2;
                repeat (k) begin
                    if ($urandom_range(99) < 8) begin
                        queue_noise();
                    end else begin
                        t += $urandom_range(span / 3 + 1);
                        queue_cmd(mss_pkg::ACT_TICK, t,
                                  mss_pkg::DVAL_W'($urandom_range(1023)));
                    end
                end
            end else begin
                queue_noise();
                left--;
            end
        end
    endfunction

    task automatic write_reg(input mss_pkg::t_cfg_idx idx,
                             input logic [mss_pkg::CFG_W-1:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            mss_pkg::CFG_WAIT:   cfg_wait_ms = val;
            mss_pkg::CFG_RUN:    cfg_run_ms = val;
            mss_pkg::CFG_RAMP:   cfg_ramp_ms = val;
            default:             cfg_target = val[mss_pkg::DUTY_W-1:0];
        endcase
    endtask

    task automatic configure(input logic [mss_pkg::CFG_W-1:0] w,
                             input logic [mss_pkg::CFG_W-1:0] r,
                             input logic [mss_pkg::CFG_W-1:0] rp,
                             input logic [mss_pkg::CFG_W-1:0] td,
                             input int mode);
        write_reg(mss_pkg::CFG_WAIT, w);
        write_reg(mss_pkg::CFG_RUN, r);
        write_reg(mss_pkg::CFG_RAMP, rp);
        write_reg(mss_pkg::CFG_TARGET, td);
        @(negedge i_clk);
        case (mode)
            1: begin send_idle_pct = 53; stall_pct = 0; end
            2: begin send_idle_pct = 0; stall_pct = 53; end
            3: begin send_idle_pct = 22; stall_pct = 22; end
            default: begin send_idle_pct = 0; stall_pct = 0; end
        endcase
    endtask

    task automatic wait_drained();
        do @(negedge i_clk);
        while (cmd_queue.size() > 0 || s_axis_tvalid || report_queue.size() > 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        cfg_wait_ms = '0;
        cfg_run_ms = '0;
        cfg_ramp_ms = '0;
        cfg_target = mss_pkg::STOP_DUTY;
        seq_phase = mss_pkg::PH_IDLE;
        seq_t0 = '0;
        duty_cur = mss_pkg::STOP_DUTY;
        ramp_on = 1'b0;
        start_held = 1'b0;
        drive_on = 1'b0;
        duty_changed = 1'b0;
        lat_wait = '0;
        lat_run = '0;
        lat_ramp = '0;
        lat_target = mss_pkg::STOP_DUTY;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // directed: duty writes at the limits, wrap of the ms clock, busy start
        configure(24'd10, 24'd100, 24'd50, 24'd100, 0);
        queue_cmd(mss_pkg::ACT_DUTY, $urandom(), 10'd0);
        queue_cmd(mss_pkg::ACT_DUTY, $urandom(), 10'd500);
        queue_cmd(mss_pkg::ACT_DUTY, $urandom(), 10'd501);
        queue_cmd(mss_pkg::ACT_DUTY, $urandom(), 10'd1023);
        queue_cmd(mss_pkg::ACT_DUTY, $urandom(), 10'd250);
        queue_cmd(mss_pkg::ACT_TICK, 32'hFFFF_FFF0, 10'd0);
        queue_cmd(mss_pkg::ACT_START, $urandom(), 10'd0);
        queue_cmd(mss_pkg::ACT_START, $urandom(), 10'd1023);
        queue_cmd(mss_pkg::ACT_TICK, 32'hFFFF_FFF8, 10'd0);
        queue_cmd(mss_pkg::ACT_START, $urandom(), 10'd0);
        queue_cmd(mss_pkg::ACT_TICK, 32'hFFFF_FFFF, 10'd1023);
        queue_cmd(mss_pkg::ACT_TICK, 32'd2, 10'd0);
        queue_cmd(mss_pkg::ACT_TICK, 32'd27, 10'd0);
        queue_cmd(mss_pkg::ACT_DUTY, $urandom(), 10'd450);
        queue_cmd(mss_pkg::ACT_TICK, 32'd52, 10'd0);
        queue_cmd(mss_pkg::ACT_TICK, 32'd200, 10'd0);
        queue_cmd(mss_pkg::ACT_TICK, 32'd201, 10'd0);
        queue_cmd(mss_pkg::ACT_TICK, 32'd202, 10'd0);
        queue_cmd(mss_pkg::ACT_START, $urandom(), 10'd0);
        queue_cmd(mss_pkg::ACT_TICK, 32'd300, 10'd0);
        queue_cmd(mss_pkg::ACT_STOP, $urandom(), 10'd0);
        queue_cmd(mss_pkg::ACT_TICK, 32'd0, 10'd0);
        wait_drained();

        configure(24'd0, 24'd0, 24'd0, 24'd0, 0);
        queue_random(210);
        wait_drained();

        configure(24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FE00, 1);
        queue_random(210);
        wait_drained();

        configure(mss_pkg::CFG_W'($urandom_range(50)), mss_pkg::CFG_W'($urandom_range(200)),
                  24'd0, 24'd250, 2);
        queue_random(210);
        wait_drained();

        // target at or above the stop value, junk in the unused data bits
        configure(mss_pkg::CFG_W'($urandom_range(1000)),
                  mss_pkg::CFG_W'($urandom_range(5000)),
                  mss_pkg::CFG_W'($urandom_range(5000)),
                  mss_pkg::CFG_W'(($urandom() & 32'hFF_FE00) | $urandom_range(511, 500)),
                  3);
        queue_random(210);
        wait_drained();

        // ramp longer than the run, so only a stray tick with a far time can complete it
        configure(mss_pkg::CFG_W'($urandom_range(300)), 24'd100, 24'd100000,
                  mss_pkg::CFG_W'($urandom_range(499)), 0);
        queue_random(210);
        wait_drained();

        configure(mss_pkg::CFG_W'($urandom()), mss_pkg::CFG_W'($urandom()),
                  mss_pkg::CFG_W'($urandom()), mss_pkg::CFG_W'($urandom()), 1);
        queue_random(210);
        wait_drained();

        configure(mss_pkg::CFG_W'($urandom_range(20)), mss_pkg::CFG_W'($urandom_range(400)),
                  mss_pkg::CFG_W'($urandom_range(400)), mss_pkg::CFG_W'($urandom_range(511)),
                  2);
        queue_random(210);
        wait_drained();

        configure(mss_pkg::CFG_W'($urandom_range(2000)),
                  mss_pkg::CFG_W'($urandom_range(20000)),
                  mss_pkg::CFG_W'($urandom_range(20000)),
                  mss_pkg::CFG_W'($urandom_range(511)), 3);
        queue_random(210);
        wait_drained();

        if (mismatch_count == 0) begin
            $display("motor_soft_start_sequencer: match");
        end else begin
            $display("motor_soft_start_sequencer: mismatch");
        end
        $finish;
    end

endmodule
